@@ hdl/bti_pkg.sv @@
// Shared constants and controller/datapath interface types for the
// breakpoint table interpolator. No dependencies.
package bti_pkg;

  localparam int MAX_POINTS = 32;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 6;
  localparam int DATA_W     = 16;
  localparam int DIV_STEPS  = DATA_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  localparam logic MODE_INTERP = 1'b0;
  localparam logic MODE_STEP   = 1'b1;

  localparam logic REG_ENTRY_COUNT = 1'b0;
  localparam logic REG_LOOKUP_MODE = 1'b1;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] rd_addr;
    logic             eval;
    logic [IDX_W-1:0] eval_idx;
    logic             decide;
    logic             div_step;
    logic             fin_interp;
  } bti_cmd_t;

  typedef struct packed {
    logic need_div;
  } bti_status_t;

endpackage

@@ hdl/breakpoint_table_interpolator.sv @@
// Top level of the breakpoint table interpolator: configuration registers,
// controller and datapath. Depends on bti_pkg, bti_controller, bti_datapath.
//
// Usage: a request is taken on a rising edge with start high and busy low.
// req_type 0 writes one breakpoint (entry_index, entry_x, entry_y); req_type
// 1 converts sample through the first entry_count breakpoints, 1 to 32 used.
// Each request gives one result on value/segment/clamped, valid for the
// single cycle in which done is high; the receiver cannot stall it.
// Write requests: result in the cycle after acceptance, busy stays low.
// Convert requests: the N breakpoints in use (1 to 32) are read one per
// cycle from the table memory (scan), then a drain and a decide state follow.
// In step mode or when the sample lies below the first or at/above the last
// x, the result is set in the decide state; interpolated ones go on through
// the 16-step bit-serial divider and a final state that forms the signed
// result. One request at a time; busy is high throughout a convert, and the
// next request can be taken in the done cycle.
// Configuration: wr_en with wr_index 0 (entry_count) or 1 (lookup_mode),
// only while idle. Reset clears the controller and sets entry_count to 2
// and interpolation mode; breakpoint contents are undefined until written.
module breakpoint_table_interpolator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      req_type,
  input  logic [bti_pkg::IDX_W-1:0] entry_index,
  input  logic [15:0]               entry_x,
  input  logic signed [15:0]        entry_y,
  input  logic [15:0]               sample,
  input  logic                      wr_en,
  input  logic                      wr_index,
  input  logic [bti_pkg::CNT_W-1:0] wr_data,
  output logic                      done,
  output logic signed [15:0]        value,
  output logic [bti_pkg::IDX_W-1:0] segment,
  output logic                      clamped
);
  import bti_pkg::*;

  logic [CNT_W-1:0] entry_count;
  logic             lookup_mode;
  logic [IDX_W-1:0] last;
  bti_cmd_t         cmd;
  bti_status_t      status;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= CNT_W'(2);
      lookup_mode <= MODE_INTERP;
    end else if (wr_en) begin
      if (wr_index == REG_ENTRY_COUNT) begin
        entry_count <= wr_data;
      end else begin
        lookup_mode <= wr_data[0];
      end
    end
  end

  always_comb begin
    if (entry_count == '0) begin
      last = '0;
    end else if (entry_count > CNT_W'(MAX_POINTS)) begin
      last = IDX_W'(MAX_POINTS - 1);
    end else begin
      last = IDX_W'(entry_count - 1'b1);
    end
  end

  bti_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .last     (last),
    .status   (status),
    .busy     (busy),
    .done     (done),
    .cmd      (cmd)
  );

  bti_datapath u_dp (
    .clk         (clk),
    .req_type    (req_type),
    .entry_index (entry_index),
    .entry_x     (entry_x),
    .entry_y     (entry_y),
    .sample      (sample),
    .lookup_mode (lookup_mode),
    .last        (last),
    .cmd         (cmd),
    .status      (status),
    .value       (value),
    .segment     (segment),
    .clamped     (clamped)
  );

endmodule

@@ hdl/bti_datapath.sv @@
// Datapath: breakpoint memories, scan capture registers, multiplier and
// restoring divider, result registers. Depends on bti_pkg.
module bti_datapath (
  input  logic                     clk,
  input  logic                     req_type,
  input  logic [bti_pkg::IDX_W-1:0] entry_index,
  input  logic [15:0]              entry_x,
  input  logic signed [15:0]       entry_y,
  input  logic [15:0]              sample,
  input  logic                     lookup_mode,
  input  logic [bti_pkg::IDX_W-1:0] last,
  input  bti_pkg::bti_cmd_t        cmd,
  output bti_pkg::bti_status_t     status,
  output logic signed [15:0]       value,
  output logic [bti_pkg::IDX_W-1:0] segment,
  output logic                     clamped
);
  import bti_pkg::*;

  logic [DATA_W-1:0] mem_x [MAX_POINTS];
  logic [DATA_W-1:0] mem_y [MAX_POINTS];
  logic [DATA_W-1:0] rd_x;
  logic [DATA_W-1:0] rd_y;

  logic [DATA_W-1:0] s;
  logic [DATA_W-1:0] prev_x;
  logic [DATA_W-1:0] prev_y;
  logic [DATA_W-1:0] x0;
  logic [DATA_W-1:0] y0;
  logic [DATA_W-1:0] xl;
  logic [DATA_W-1:0] yl;
  logic              step_found;
  logic [DATA_W-1:0] step_y;
  logic [IDX_W-1:0]  step_i;
  logic              int_found;
  logic [DATA_W-1:0] ix0;
  logic [DATA_W-1:0] iy0;
  logic [DATA_W-1:0] ix1;
  logic [DATA_W-1:0] iy1;
  logic [IDX_W-1:0]  iseg;

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dx;
  logic              neg;

  logic              clamp_c;
  logic signed [DATA_W:0] dy;
  logic [DATA_W-1:0] dy_abs;
  logic [DATA_W-1:0] off;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W:0]   trial;
  logic              trial_ok;
  logic [DATA_W-1:0] q_signed;

  always_ff @(posedge clk) begin
    if (cmd.load && req_type == REQ_WRITE) begin
      mem_x[entry_index] <= entry_x;
      mem_y[entry_index] <= entry_y;
    end
    rd_x <= mem_x[cmd.rd_addr];
    rd_y <= mem_y[cmd.rd_addr];
  end

  assign clamp_c = (s < x0) || (s > xl);
  assign status.need_div = (lookup_mode == MODE_INTERP) && !(s < x0) && !(s >= xl);

  assign dy     = $signed({iy1[DATA_W-1], iy1}) - $signed({iy0[DATA_W-1], iy0});
  assign dy_abs = dy[DATA_W] ? DATA_W'(-dy) : dy[DATA_W-1:0];
  assign off    = s - ix0;
  assign prod   = {{DATA_W{1'b0}}, off} * {{DATA_W{1'b0}}, dy_abs};

  assign trial    = {rem, quo[DATA_W-1]};
  assign trial_ok = trial >= {1'b0, dx};
  assign q_signed = neg ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (req_type == REQ_WRITE) begin
        value   <= '0;
        segment <= '0;
        clamped <= 1'b0;
      end else begin
        s <= sample;
      end
      step_found <= 1'b0;
      int_found  <= 1'b0;
    end

    if (cmd.eval) begin
      if (cmd.eval_idx == '0) begin
        x0 <= rd_x;
        y0 <= rd_y;
      end
      if (cmd.eval_idx == last) begin
        xl <= rd_x;
        yl <= rd_y;
      end
      if (!step_found && cmd.eval_idx < last && rd_x >= s) begin
        step_found <= 1'b1;
        step_y     <= rd_y;
        step_i     <= cmd.eval_idx;
      end
      // fall back to the final segment when no upper x exceeds the sample
      if (!int_found && cmd.eval_idx != '0 && (rd_x > s || cmd.eval_idx == last)) begin
        int_found <= 1'b1;
        ix0       <= prev_x;
        iy0       <= prev_y;
        ix1       <= rd_x;
        iy1       <= rd_y;
        iseg      <= cmd.eval_idx - 1'b1;
      end
      prev_x <= rd_x;
      prev_y <= rd_y;
    end

    if (cmd.decide) begin
      rem <= prod[2*DATA_W-1:DATA_W];
      quo <= prod[DATA_W-1:0];
      dx  <= ix1 - ix0;
      neg <= dy[DATA_W];
      if (!status.need_div) begin
        clamped <= clamp_c;
        if (lookup_mode == MODE_STEP) begin
          value   <= step_found ? step_y : yl;
          segment <= step_found ? step_i : last;
        end else if (s < x0) begin
          value   <= y0;
          segment <= '0;
        end else begin
          value   <= yl;
          segment <= last;
        end
      end
    end

    if (cmd.div_step) begin
      rem <= trial_ok ? (trial[DATA_W-1:0] - dx) : trial[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], trial_ok};
    end

    if (cmd.fin_interp) begin
      value   <= iy0 + q_signed;
      segment <= iseg;
      clamped <= clamp_c;
    end
  end

endmodule

@@ hdl/bti_controller.sv @@
// Controller FSM: sequences breakpoint scan, decision, division and result
// strobe. Depends on bti_pkg.
module bti_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      req_type,
  input  logic [bti_pkg::IDX_W-1:0] last,
  input  bti_pkg::bti_status_t      status,
  output logic                      busy,
  output logic                      done,
  output bti_pkg::bti_cmd_t         cmd
);
  import bti_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_DIV,
    S_FIN
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     k;
  logic                 eval_valid;
  logic [IDX_W-1:0]     eval_idx;
  logic [DIV_CNT_W-1:0] div_cnt;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd.load       = (state == S_IDLE) && start;
    cmd.rd_addr    = k;
    cmd.eval       = eval_valid;
    cmd.eval_idx   = eval_idx;
    cmd.decide     = (state == S_DECIDE);
    cmd.div_step   = (state == S_DIV);
    cmd.fin_interp = (state == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      k          <= '0;
      eval_valid <= 1'b0;
      eval_idx   <= '0;
      div_cnt    <= '0;
    end else begin
      done       <= 1'b0;
      eval_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            k <= '0;
            if (req_type == REQ_CONVERT) begin
              state <= S_SCAN;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          eval_valid <= 1'b1;
          eval_idx   <= k;
          if (k == last) begin
            state <= S_DRAIN;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          div_cnt <= '0;
          if (status.need_div) begin
            state <= S_DIV;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither started nor completed");

  a_no_eval_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !eval_valid)
    else $error("scan capture outside a conversion");

  a_div_flow: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |=> (state == S_DIV || state == S_FIN))
    else $error("divider sequence broken");

endmodule

@@ verif/bti_calib_checker.sv @@
// Result checker for the breakpoint table interpolator: mirrors the table and
// configuration, predicts every result and compares it with the block's output.
// Depends on bti_pkg.
module bti_calib_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      req_type,
  input  logic [bti_pkg::IDX_W-1:0] entry_index,
  input  logic [15:0]               entry_x,
  input  logic signed [15:0]        entry_y,
  input  logic [15:0]               sample,
  input  logic                      wr_en,
  input  logic                      wr_index,
  input  logic [bti_pkg::CNT_W-1:0] wr_data,
  input  logic                      done,
  input  logic signed [15:0]        value,
  input  logic [bti_pkg::IDX_W-1:0] segment,
  input  logic                      clamped,
  output int                        results_owed,
  output int                        errors
);
  timeunit 1ns;
  timeprecision 1ps;
  import bti_pkg::*;

  typedef struct packed {
    logic signed [15:0] value;
    logic [IDX_W-1:0]   segment;
    logic               clamped;
  } calib_t;

  calib_t             expected_calib [$];
  logic [15:0]        table_x [MAX_POINTS];
  logic signed [15:0] table_y [MAX_POINTS];
  logic [CNT_W-1:0]   points_reg;
  logic               mode_reg;

  function automatic calib_t interpolate_sample(logic [15:0] s);
    int     n;
    int     last;
    int     i;
    longint dx;
    longint dy;
    longint off;
    longint acc;
    calib_t r;
    n = points_reg;
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    last = n - 1;
    r.clamped = (s < table_x[0]) || (s > table_x[last]);
    if (mode_reg == MODE_STEP) begin
      i = 0;
      while (i < last && table_x[i] < s) i++;
      acc = longint'(table_y[i]);
    end else if (s < table_x[0]) begin
      i = 0;
      acc = longint'(table_y[0]);
    end else if (s >= table_x[last]) begin
      i = last;
      acc = longint'(table_y[last]);
    end else begin
      i = 0;
      while (i < last - 1 && !(table_x[i+1] > s)) i++;
      dx  = longint'(table_x[i+1]) - longint'(table_x[i]);
      dy  = longint'(table_y[i+1]) - longint'(table_y[i]);
      off = longint'(s) - longint'(table_x[i]);
      if (dx <= 0) dx = 1;
      acc = longint'(table_y[i]) + (off * dy) / dx;
    end
    r.value   = acc[15:0];
    r.segment = i[IDX_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, logic signed [31:0] exp_v, logic signed [31:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : monitor
    calib_t exp_r;
    if (rst) begin
      expected_calib.delete();
      points_reg = CNT_W'(2);
      mode_reg = MODE_INTERP;
      errors = 0;
      results_owed <= 0;
    end else begin
      if (done) begin
        if (expected_calib.size() == 0) begin
          errors++;
          $error("result with no request outstanding: value %0d segment %0d clamped %0d",
                 value, segment, clamped);
        end else begin
          exp_r = expected_calib.pop_front();
          check_field("value", exp_r.value, value);
          check_field("segment", exp_r.segment, segment);
          check_field("clamped", exp_r.clamped, clamped);
        end
      end
      if (start && !busy) begin
        if (req_type == REQ_WRITE) begin
          table_x[entry_index] = entry_x;
          table_y[entry_index] = entry_y;
          expected_calib.push_back('0);
        end else begin
          expected_calib.push_back(interpolate_sample(sample));
        end
      end
      if (wr_en) begin
        if (wr_index == REG_ENTRY_COUNT) points_reg = wr_data;
        else mode_reg = wr_data[0];
      end
      results_owed <= expected_calib.size();
    end
  end

endmodule

@@ verif/tb.sv @@
// Testbench top for the breakpoint table interpolator: clock, reset, directed
// and random requests and register writes, final verdict.
// Depends on bti_pkg, breakpoint_table_interpolator and bti_calib_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bti_pkg::*;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic                req_type;
  logic [IDX_W-1:0]    entry_index;
  logic [15:0]         entry_x;
  logic signed [15:0]  entry_y;
  logic [15:0]         sample;
  logic                wr_en;
  logic                wr_index;
  logic [CNT_W-1:0]    wr_data;
  logic                done;
  logic signed [15:0]  value;
  logic [IDX_W-1:0]    segment;
  logic                clamped;
  int                  results_owed;
  int                  errors;

  int unsigned         idle_pct;
  int                  items_sent;
  logic [15:0]         stim_x [MAX_POINTS];

  breakpoint_table_interpolator uut (.*);
  bti_calib_checker checker_i (.*);

  always #5 clk = ~clk;

  task automatic send_request(logic rt, logic [IDX_W-1:0] idx, logic [15:0] x,
                              logic [15:0] y, logic [15:0] s);
    while ($urandom_range(99) < idle_pct) begin
      start       <= 1'b0;
      req_type    <= 1'($urandom_range(1));
      entry_index <= IDX_W'($urandom);
      entry_x     <= 16'($urandom);
      entry_y     <= 16'($urandom);
      sample      <= 16'($urandom);
      @(posedge clk);
    end
    start       <= 1'b1;
    req_type    <= rt;
    entry_index <= idx;
    entry_x     <= x;
    entry_y     <= y;
    sample      <= s;
    if (rt == REQ_WRITE) stim_x[idx] = x;
    items_sent++;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_entry(logic [IDX_W-1:0] idx, logic [15:0] x, logic [15:0] y);
    send_request(REQ_WRITE, idx, x, y, 16'($urandom));
  endtask

  task automatic convert(logic [15:0] s);
    send_request(REQ_CONVERT, IDX_W'($urandom), 16'($urandom), 16'($urandom), s);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (results_owed != 0 || busy) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [CNT_W-1:0] data);
    drain();
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en    <= 1'b0;
    wr_index <= 1'($urandom);
    wr_data  <= CNT_W'($urandom);
  endtask

  function automatic int eff_points(int c);
    if (c < 1) return 1;
    if (c > MAX_POINTS) return MAX_POINTS;
    return c;
  endfunction

  // samples cluster on and around the breakpoints
  function automatic logic [15:0] pick_sample(int n);
    int k;
    int v;
    k = $urandom_range(n - 1);
    case ($urandom_range(9))
      0:       v = 0;
      1:       v = 65535;
      2, 3:    v = int'(stim_x[k]);
      4, 5:    v = int'(stim_x[k]) + int'($urandom_range(8)) - 4;
      6, 7:    v = (k < n - 1) ? (int'(stim_x[k]) + int'(stim_x[k+1])) / 2 : int'(stim_x[k]);
      default: v = $urandom_range(65535);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  task automatic load_table(int n, bit ordered);
    int x;
    x = $urandom_range(3000);
    for (int k = 0; k < n; k++) begin
      if (ordered) begin
        write_entry(IDX_W'(k), x[15:0], 16'($urandom));
        if ($urandom_range(3) != 0) x += $urandom_range(60000 / n);
        if (x > 65535) x = 65535;
      end else begin
        write_entry(IDX_W'(k), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int          phase;
    int          cnt;
    int          n;
    logic        mode;
    logic [4:0]  mode_pad;
    rst         <= 1'b1;
    start       <= 1'b0;
    req_type    <= REQ_WRITE;
    entry_index <= '0;
    entry_x     <= '0;
    entry_y     <= '0;
    sample      <= '0;
    wr_en       <= 1'b0;
    wr_index    <= REG_ENTRY_COUNT;
    wr_data     <= '0;
    idle_pct    = 0;
    items_sent  = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // two-point table at reset settings, full y range
    write_entry(5'd0, 16'd1000, 16'h8000);
    write_entry(5'd1, 16'd3000, 16'h7fff);
    convert(16'd0);
    convert(16'd1000);
    convert(16'd2000);
    convert(16'd2999);
    convert(16'd3000);
    convert(16'hffff);
    set_reg(REG_LOOKUP_MODE, {5'b10101, MODE_STEP});
    convert(16'd0);
    convert(16'd1000);
    convert(16'd1001);
    convert(16'd3000);
    convert(16'hffff);
    // zero count behaves as a single point
    set_reg(REG_ENTRY_COUNT, 6'd0);
    convert(16'd999);
    convert(16'd1001);
    set_reg(REG_LOOKUP_MODE, {5'b01010, MODE_INTERP});
    convert(16'd999);
    convert(16'd1000);
    convert(16'd1001);
    // out of order breakpoints
    write_entry(5'd2, 16'd0, 16'd7);
    write_entry(5'd3, 16'hffff, 16'hffff);
    set_reg(REG_ENTRY_COUNT, 6'd3);
    convert(16'd500);
    convert(16'd2000);
    set_reg(REG_ENTRY_COUNT, 6'd4);
    convert(16'd40000);
    set_reg(REG_LOOKUP_MODE, {5'b00000, MODE_STEP});
    convert(16'd2000);

    phase = 0;
    while (items_sent < 850) begin
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 85;
        default: idle_pct = 12;
      endcase
      case (phase)
        0:       cnt = 63;
        1:       cnt = MAX_POINTS;
        2:       cnt = 1;
        3:       cnt = 0;
        4:       cnt = 2;
        default: cnt = $urandom_range(63);
      endcase
      mode = (phase < 8) ? phase[0] : 1'($urandom_range(1));
      mode_pad = 5'($urandom);
      set_reg(REG_ENTRY_COUNT, cnt[CNT_W-1:0]);
      set_reg(REG_LOOKUP_MODE, {mode_pad, mode});
      n = eff_points(cnt);
      if (phase == 0) load_table(MAX_POINTS, 1'b1);
      else if ($urandom_range(3) != 0) load_table(n, $urandom_range(4) != 0);
      for (int j = 0; j < 40; j++) begin
        if (j == 20) drain();
        if ($urandom_range(4) == 0) begin
          write_entry(IDX_W'($urandom), 16'($urandom), 16'($urandom));
        end else begin
          convert(pick_sample(n));
        end
      end
      phase++;
    end

    drain();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
